// ===== hw/rtl/debounced_multi_click_counter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the debounced multi-click counter.
// Both expect clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_MULTI_CLICK_COUNTER_MACROS_SVH
`define DEBOUNCED_MULTI_CLICK_COUNTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DMCC_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DMCC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== hw/rtl/dmcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmcc_pkg
// Types and fixed constants of the debounced multi-click counter.
// ----------------------------------------------------------------------------
package dmcc_pkg;

  localparam int CFG_BITS     = 16;
  localparam int COUNT_BITS   = 8;
  localparam int IN_TICK_BITS = 32;

  typedef logic [0:0]            cfg_idx_t;
  typedef logic [CFG_BITS-1:0]   cfg_val_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam cfg_idx_t CFG_IDX_DEBOUNCE  = 1'b0;
  localparam cfg_idx_t CFG_IDX_CLICK_GAP = 1'b1;

  localparam cfg_val_t DEBOUNCE_RST  = 16'd50;
  localparam cfg_val_t CLICK_GAP_RST = 16'd250;

endpackage

// ===== hw/rtl/debounced_multi_click_counter.sv =====
// ----------------------------------------------------------------------------
// debounced_multi_click_counter
// Counts debounced button presses and reports a burst once the line goes quiet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one poll per item, carrying the sampled
//   line level and the free-running tick value.
//   Output channel (out_valid/out_ready): exactly one item per poll, the
//   finished click count of a burst, or 0 when there is nothing to report.
//   Config port (cfg_we/cfg_index/cfg_wdata): debounce and click-gap limits in
//   ticks; the user must write them only while the block is idle (unchecked).
//   An accepted poll's result is registered in the output or skid register.
//   Throughput: 1 item per cycle while in_ready is high; the poll update is one
//   combinational pass between the state registers and the output register.
//   A two-entry output buffer (output register plus skid) keeps in_ready high
//   while one result waits; in_ready drops only when both entries are full.
//   Reset: limits return to 50 and 250 ticks, all tracking state clears and
//   the output buffer empties.
// ----------------------------------------------------------------------------
`include "debounced_multi_click_counter_macros.svh"

module debounced_multi_click_counter import dmcc_pkg::*; #(
  parameter int TICK_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  cfg_idx_t                cfg_index,
  input  cfg_val_t                cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_line_level,
  input  logic [IN_TICK_BITS-1:0] in_now_tick,
  output logic                    out_valid,
  input  logic                    out_ready,
  output count_t                  out_click_total
);

  cfg_val_t debounce_r, click_gap_r;

  logic                 held_level_r, held_level_nxt;
  logic [TICK_BITS-1:0] edge_time_r, edge_time_nxt;
  logic                 click_taken_r, click_taken_nxt;
  count_t               pending_r, pending_nxt;
  logic [TICK_BITS-1:0] last_click_r, last_click_nxt;

  logic   out_valid_r, out_valid_nxt;
  count_t out_data_r, out_data_nxt;
  logic   skid_valid_r, skid_valid_nxt;
  count_t skid_data_r, skid_data_nxt;

  logic                 in_fire, out_fire;
  logic [TICK_BITS-1:0] now_t, since_edge, since_click;
  logic                 level_change, click_now;
  count_t               pend_upd, report;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_fire  = out_valid_r && out_ready;
  assign out_click_total = out_data_r;

  // ---------------- poll update ----------------
  assign now_t        = TICK_BITS'(in_now_tick);
  assign since_edge   = now_t - edge_time_r;
  assign since_click  = now_t - last_click_r;
  assign level_change = in_line_level != held_level_r;
  assign click_now    = !level_change && held_level_r && !click_taken_r &&
                        (since_edge > TICK_BITS'(debounce_r));
  assign pend_upd     = click_now ? pending_r + count_t'(1) : pending_r;

  // a click taken this poll has zero gap, so it can never report here
  always_comb begin
    report = '0;
    if (pend_upd != '0 && !click_now && since_click > TICK_BITS'(click_gap_r)) begin
      report = pend_upd;
    end
  end

  always_comb begin
    held_level_nxt  = held_level_r;
    edge_time_nxt   = edge_time_r;
    click_taken_nxt = click_taken_r;
    pending_nxt     = pending_r;
    last_click_nxt  = last_click_r;
    if (in_fire) begin
      if (level_change) begin
        held_level_nxt  = in_line_level;
        edge_time_nxt   = now_t;
        click_taken_nxt = 1'b0;
      end else if (click_now) begin
        click_taken_nxt = 1'b1;
        last_click_nxt  = now_t;
      end
      pending_nxt = (report != '0) ? '0 : pend_upd;
    end
  end

  // ---------------- output buffer ----------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = report;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = report;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      click_gap_r   <= CLICK_GAP_RST;
      held_level_r  <= 1'b0;
      edge_time_r   <= '0;
      click_taken_r <= 1'b0;
      pending_r     <= '0;
      last_click_r  <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_DEBOUNCE:  debounce_r  <= cfg_wdata;
          CFG_IDX_CLICK_GAP: click_gap_r <= cfg_wdata;
          default: ;
        endcase
      end
      held_level_r  <= held_level_nxt;
      edge_time_r   <= edge_time_nxt;
      click_taken_r <= click_taken_nxt;
      pending_r     <= pending_nxt;
      last_click_r  <= last_click_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // ---------------- assertions ----------------
  `DMCC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `DMCC_ASSERT_NEXT(a_click_marks_taken, in_fire && click_now, click_taken_r && held_level_r, "counted click not marked")
  `DMCC_ASSERT_NEXT(a_report_clears, in_fire && report != '0, pending_r == '0, "reported clicks still pending")

endmodule
